// File: rtl/pmrld_pkg.sv
// Package for the mixed run-length scanline decoder: decode phases, packet
// header codes, status codes and register indexes. No dependencies.
`default_nettype none

package pmrld_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned CHIDX_W   = 2;
  localparam int unsigned RAWCNT_W  = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // Packet header codes
  localparam logic [BYTE_W-1:0] HDR_LONG_RUN  = 8'd128;
  localparam logic [BYTE_W-1:0] HDR_RUN_BIAS  = 8'd127;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SWAPPED  = 2'd2;

  // Register reset values
  localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = 3'd4;
  localparam logic [COUNT_W-1:0] LINE_PIXELS_RST   = 16'd1024;
  localparam logic               LONG_SWAPPED_RST  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DECODING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LINE_END = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LONG_A = 3'd1,
    PH_LONG_B = 3'd2,
    PH_REPEAT = 3'd3,
    PH_RAW    = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

endpackage

`default_nettype wire

// File: rtl/pic_mixed_rle_line_decoder.sv
// Mixed run-length scanline decoder: one stream byte in, at most one run
// descriptor out. Depends on pmrld_pkg.
`default_nettype none

// Usage
//   Slave side: one compressed byte per word in s_tdata[7:0]; s_tlast marks
//   the final available byte, after which all decode state returns to reset.
//   Master side: one run descriptor per word. m_tdata carries the pixel
//   (channel 0 in the low byte), the repeat count clipped to the pixels left
//   in the line and the start index; m_tuser carries the status (decoding,
//   line complete, input ended mid-packet). A status-only word has repeat
//   count 0.
//   Config: write channel_count, line_pixels and long_count_swapped through
//   cfg_we/cfg_index/cfg_data while the stream is idle.
// Timing
//   Each accepted byte is decoded in the cycle it is taken; its descriptor
//   appears in the next cycle from the output register. One byte per cycle
//   sustained while m_tready does not stall: the state machine and the clip
//   compare sit between the input handshake and that register.
// Reset and stall
//   rst (synchronous) restores registers to their defaults, clears decode
//   state and empties the output register. While a descriptor waits on
//   m_tready, s_tready drops; it rises again in the cycle the word is taken.
module pic_mixed_rle_line_decoder
  import pmrld_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave side
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
  input  wire logic                 s_tlast,   // buffer_end
  // master side
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // [31:0] pixel_value,
                                               // [47:32] repeat_count,
                                               // [63:48] start_index
  output logic [STATUS_W-1:0]       m_tuser,   // [1:0] status
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [CHAN_W-1:0]  channel_count;
  logic [COUNT_W-1:0] line_pixels;
  logic               long_count_swapped;

  // Decode state
  phase_t              phase, phase_step, phase_next;
  logic [COUNT_W-1:0]  run_count, run_count_next;
  logic [CHIDX_W-1:0]  channel_index, channel_index_next;
  logic [PIXEL_W-1:0]  pixel_gather, pixel_gather_next;
  logic [COUNT_W-1:0]  pixels_done, pixels_done_next;
  logic [RAWCNT_W-1:0] raw_left, raw_left_next;

  // Result of the current byte
  logic                res_valid;
  logic [PIXEL_W-1:0]  res_pixel;
  logic [COUNT_W-1:0]  res_count;
  logic [COUNT_W-1:0]  res_start;
  logic [STATUS_W-1:0] res_status;

  logic               s_accept;
  logic [BYTE_W-1:0]  byte_in;
  logic [CHAN_W-1:0]  eff_ch;
  logic [COUNT_W-1:0] eff_lim;
  logic [PIXEL_W-1:0] gather_new;
  logic               ci_last;
  logic [COUNT_W-1:0] emit_count;
  logic [COUNT_W-1:0] emit_left;
  logic [COUNT_W-1:0] emit_n;
  logic [COUNT_W-1:0] done_sum;
  logic               emit_full;
  logic               emit_fire;
  logic [RAWCNT_W-1:0] raw_dec;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign byte_in  = s_tdata[BYTE_W-1:0];

  // Out-of-range channel counts clamp to 1..4, a zero line length acts as 1
  assign eff_ch  = (channel_count == '0) ? 3'd1 :
                   (channel_count > 3'd4) ? 3'd4 : channel_count;
  assign eff_lim = (line_pixels == '0) ? 16'd1 : line_pixels;

  assign gather_new = pixel_gather |
                      ({24'd0, byte_in} << {channel_index, 3'b000});
  assign ci_last    = ({1'b0, channel_index} + 3'd1) >= eff_ch;
  assign raw_dec    = raw_left - 8'd1;

  // Clip the run to the pixels left in the line
  assign emit_count = (phase == PH_REPEAT) ? run_count : 16'd1;
  assign emit_left  = (pixels_done < eff_lim) ? (eff_lim - pixels_done) : '0;
  assign emit_n     = (emit_count < emit_left) ? emit_count : emit_left;
  assign done_sum   = pixels_done + emit_n;
  assign emit_full  = done_sum >= eff_lim;
  assign emit_fire  = ci_last &&
                      (((phase == PH_REPEAT) && (run_count != '0)) || (phase == PH_RAW));

  // Next phase
  always_comb begin
    phase_step = phase;
    case (phase)
      PH_HEADER: begin
        if (byte_in < HDR_LONG_RUN) phase_step = PH_RAW;
        else if (byte_in == HDR_LONG_RUN) phase_step = PH_LONG_A;
        else phase_step = PH_REPEAT;
      end
      PH_LONG_A: phase_step = PH_LONG_B;
      PH_LONG_B: phase_step = PH_REPEAT;
      PH_REPEAT: begin
        if (ci_last) phase_step = PH_HEADER;
      end
      PH_RAW: begin
        if (ci_last) begin
          if (raw_dec == '0) phase_step = PH_HEADER;
          else if (emit_full) phase_step = PH_SKIP;  // line filled mid-packet
        end
      end
      PH_SKIP: begin
        if (ci_last && raw_dec == '0) phase_step = PH_HEADER;
      end
      default: phase_step = PH_HEADER;
    endcase
    phase_next = s_tlast ? PH_HEADER : phase_step;
  end

  // Datapath and result
  always_comb begin
    run_count_next     = run_count;
    channel_index_next = channel_index;
    pixel_gather_next  = pixel_gather;
    pixels_done_next   = pixels_done;
    raw_left_next      = raw_left;
    res_valid          = 1'b0;
    res_pixel          = gather_new;
    res_count          = emit_n;
    res_start          = pixels_done;
    res_status         = emit_full ? ST_LINE_END : ST_DECODING;

    case (phase)
      PH_HEADER: begin
        pixel_gather_next  = '0;
        channel_index_next = '0;
        if (byte_in < HDR_LONG_RUN) raw_left_next = byte_in + 8'd1;
        else if (byte_in != HDR_LONG_RUN)
          run_count_next = {8'd0, byte_in - HDR_RUN_BIAS};
      end
      PH_LONG_A: begin
        run_count_next = long_count_swapped ? {byte_in, 8'd0} : {8'd0, byte_in};
      end
      PH_LONG_B: begin
        run_count_next = run_count |
                         (long_count_swapped ? {8'd0, byte_in} : {byte_in, 8'd0});
      end
      PH_REPEAT: begin
        pixel_gather_next = gather_new;
        if (ci_last) channel_index_next = '0;
        else channel_index_next = channel_index + 2'd1;
      end
      PH_RAW, PH_SKIP: begin
        if (phase == PH_RAW) pixel_gather_next = gather_new;
        if (ci_last) begin
          channel_index_next = '0;
          raw_left_next      = raw_dec;
          if (phase == PH_RAW) pixel_gather_next = '0;
        end else begin
          channel_index_next = channel_index + 2'd1;
        end
      end
      default: ;
    endcase

    // Advance line progress on each emitted run; wrap at line end
    if (emit_fire) begin
      res_valid        = 1'b1;
      pixels_done_next = emit_full ? '0 : done_sum;
    end

    // Final byte: flag a cut packet, then drop all decode state
    if (s_tlast) begin
      if (phase_step != PH_HEADER) begin
        if (emit_fire) begin
          if (!emit_full) res_status = ST_TRUNC;
        end else begin
          res_valid  = 1'b1;
          res_pixel  = '0;
          res_count  = '0;
          res_start  = pixels_done;
          res_status = ST_TRUNC;
        end
      end
      run_count_next     = '0;
      channel_index_next = '0;
      pixel_gather_next  = '0;
      pixels_done_next   = '0;
      raw_left_next      = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count      <= CHANNEL_COUNT_RST;
      line_pixels        <= LINE_PIXELS_RST;
      long_count_swapped <= LONG_SWAPPED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count      <= cfg_data[CHAN_W-1:0];
        REG_LINE_PIXELS:   line_pixels        <= cfg_data[COUNT_W-1:0];
        REG_LONG_SWAPPED:  long_count_swapped <= cfg_data[0];
        default: ;  // ignore unmapped indexes
      endcase
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      run_count     <= '0;
      channel_index <= '0;
      pixel_gather  <= '0;
      pixels_done   <= '0;
      raw_left      <= '0;
    end else if (s_accept) begin
      phase         <= phase_next;
      run_count     <= run_count_next;
      channel_index <= channel_index_next;
      pixel_gather  <= pixel_gather_next;
      pixels_done   <= pixels_done_next;
      raw_left      <= raw_left_next;
    end
  end

  // Output register: load when a result is due, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && res_valid) begin
      m_tdata <= {res_start, res_count, res_pixel};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire
